[hw/rtl/tcc_pkg.sv]
// ----------------------------------------------------------------------------
// tcc_pkg
// Types and constants shared by the terrain cell colorizer pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

  // One terrain cell as it enters the block.
  typedef struct packed {
    logic [15:0] soil_mm;
    logic [15:0] surface_mm;
    logic [15:0] water_mm;
    logic [15:0] flow_count;
  } in_item_t;

  // One cell color as it leaves the block.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [15:0] bare_soil_limit_mm;
    logic [15:0] channel_flow_limit;
    logic [15:0] height_base_mm;
  } cfg_t;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BARE_SOIL_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_FLOW_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_BASE = 2'd2;

  localparam logic [15:0] RST_BARE_SOIL_LIMIT = 16'd5;
  localparam logic [15:0] RST_CHANNEL_FLOW_LIMIT = 16'd12;
  localparam logic [15:0] RST_HEIGHT_BASE = 16'd10000;

  // Height span of the grass ramp and the water depth breakpoints.
  localparam logic [14:0] SPAN_MM = 15'd20000;
  localparam logic [15:0] SHALLOW_MM = 16'd50;
  localparam logic [8:0] DEEP_SPAN_MM = 9'd450;
  localparam logic [8:0] SHALLOW_ALPHA = 9'd154;
  localparam logic [6:0] SHALLOW_SLOPE = 7'd77;   // 154 / 50 = 77 / 25
  localparam logic [4:0] DEEP_SLOPE = 5'd17;      // 102 / 450 = 17 / 75

  // Reciprocals for the constant divisions; all quotients are exact over
  // the operand ranges that reach them.
  localparam logic [18:0] RECIP_625 = 19'd429497;   // ceil(2^28 / 625)
  localparam int RECIP_625_SH = 28;
  localparam logic [15:0] RECIP_25 = 16'd41944;     // ceil(2^20 / 25)
  localparam logic [13:0] RECIP_75 = 14'd13982;     // ceil(2^20 / 75)
  localparam int RECIP_SMALL_SH = 20;

  localparam logic [8:0] ONE_Q8 = 9'd256;
  localparam logic [8:0] HALF_Q8 = 9'd128;
  localparam logic [7:0] SED_MIX_Q8 = 8'd77;
  localparam logic [7:0] GRASS_MIX_Q8 = 8'd179;

  // Colors, index 2 is red, 1 is green, 0 is blue.
  typedef logic [2:0][7:0] rgb_t;
  localparam rgb_t ROCK_RGB = '{8'd135, 8'd125, 8'd125};
  localparam rgb_t SED_RGB = '{8'd170, 8'd150, 8'd130};
  localparam rgb_t GRASS_LOW_RGB = '{8'd60, 8'd120, 8'd60};
  localparam rgb_t GRASS_MID_RGB = '{8'd110, 8'd95, 8'd50};
  localparam rgb_t GRASS_TOP_RGB = '{8'd180, 8'd180, 8'd180};
  localparam rgb_t WATER_RGB = '{8'd30, 8'd90, 8'd220};

  // After classification: land class, clamped height offset and the
  // numerator of the water alpha ramp.
  typedef struct packed {
    logic        bare;
    logic        chan;
    logic        wet;
    logic        shallow;
    logic [14:0] d_mm;
    logic [12:0] a_num;
  } s1_t;

  // After scaling: ramp position and water alpha, both Q0.8.
  typedef struct packed {
    logic       bare;
    logic       chan;
    logic [8:0] n;
    logic [8:0] alpha;
  } s2_t;

endpackage

`default_nettype wire

[hw/rtl/tcc_prep.sv]
// ----------------------------------------------------------------------------
// tcc_prep
// First pipeline stage: classifies the cell, clamps the height offset and
// forms the numerator of the water alpha ramp.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_prep (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tcc_pkg::cfg_t    cfg,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire tcc_pkg::in_item_t in_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output tcc_pkg::s1_t          out_data
);
  import tcc_pkg::*;

  logic        vld_r;
  s1_t         data_r;
  s1_t         data_nxt;
  logic [16:0] diff;
  logic [15:0] excess;
  logic [8:0]  excess_clamped;

  assign in_ready = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_data = data_r;

  always_comb begin
    data_nxt.bare = in_item.soil_mm <= cfg.bare_soil_limit_mm;
    data_nxt.wet = in_item.water_mm != 16'd0;
    data_nxt.chan = (in_item.flow_count > cfg.channel_flow_limit) || data_nxt.wet;

    diff = {1'b0, in_item.surface_mm} - {1'b0, cfg.height_base_mm};
    if (diff[16]) begin
      data_nxt.d_mm = '0;
    end else if (diff[15:0] > {1'b0, SPAN_MM}) begin
      data_nxt.d_mm = SPAN_MM;
    end else begin
      data_nxt.d_mm = diff[14:0];
    end

    // Shallow water rises at 77/25 per mm, deep water at 17/75 per mm
    // over the first 450 mm past the breakpoint.
    data_nxt.shallow = in_item.water_mm < SHALLOW_MM;
    excess = in_item.water_mm - SHALLOW_MM;
    excess_clamped = (excess > {7'd0, DEEP_SPAN_MM}) ? DEEP_SPAN_MM : excess[8:0];
    if (data_nxt.shallow) begin
      data_nxt.a_num = 13'(in_item.water_mm[5:0] * SHALLOW_SLOPE);
    end else begin
      data_nxt.a_num = 13'(excess_clamped * DEEP_SLOPE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tcc_scale.sv]
// ----------------------------------------------------------------------------
// tcc_scale
// Second pipeline stage: turns the height offset into a Q0.8 ramp position
// and the water numerator into a Q0.8 alpha by reciprocal multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_scale (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire tcc_pkg::s1_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output tcc_pkg::s2_t      out_data
);
  import tcc_pkg::*;

  logic        vld_r;
  s2_t         data_r;
  s2_t         data_nxt;
  logic [36:0] n_prod;
  logic [28:0] shallow_prod;
  logic [26:0] deep_prod;

  assign in_ready = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_data = data_r;

  always_comb begin
    data_nxt.bare = in_data.bare;
    data_nxt.chan = in_data.chan;

    // n = floor(d * 256 / 20000) = floor(8d / 625)
    n_prod = 37'({in_data.d_mm, 3'b000}) * 37'(RECIP_625);
    data_nxt.n = n_prod[RECIP_625_SH +: 9];

    shallow_prod = 29'(in_data.a_num) * 29'(RECIP_25);
    deep_prod = 27'(in_data.a_num) * 27'(RECIP_75);
    if (!in_data.wet) begin
      data_nxt.alpha = '0;
    end else if (in_data.shallow) begin
      data_nxt.alpha = shallow_prod[RECIP_SMALL_SH +: 9];
    end else begin
      data_nxt.alpha = SHALLOW_ALPHA + {2'b00, deep_prod[RECIP_SMALL_SH +: 7]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

`ifndef SYNTHESIS
  a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> data_r.alpha <= ONE_Q8)
    else $error("water alpha above one");

  a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> data_r.n <= ONE_Q8)
    else $error("ramp position above one");

  // A grass cell is dry, so it must carry no water alpha.
  a_grass_dry: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !data_r.bare && !data_r.chan) |-> data_r.alpha == 9'd0)
    else $error("grass cell with nonzero water alpha");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !out_ready) |=> (vld_r && $stable(data_r)))
    else $error("stalled item lost or changed");
`endif

endmodule

`default_nettype wire

[hw/rtl/tcc_color.sv]
// ----------------------------------------------------------------------------
// tcc_color
// Last three pipeline stages: grass ramp, land color selection with the
// sediment mix, and the blend toward water blue.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_color (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire tcc_pkg::s2_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output tcc_pkg::out_item_t out_item
);
  import tcc_pkg::*;

  // Ramp stage
  logic            v3_r;
  logic            bare3_r;
  logic            chan3_r;
  logic [8:0]      alpha3_r;
  rgb_t            g3_r;
  rgb_t            g3_nxt;
  logic            n_low;
  logic [8:0]      n_off;
  logic [8:0]      t;
  logic [8:0]      t_inv;
  logic [2:0][16:0] ramp_sum;

  // Land stage
  logic            v4_r;
  logic [8:0]      alpha4_r;
  rgb_t            land4_r;
  rgb_t            land4_nxt;
  logic [2:0][16:0] mix_sum;

  // Blend stage
  logic            v5_r;
  rgb_t            rgb5_r;
  rgb_t            rgb5_nxt;
  logic [8:0]      alpha_inv;
  logic [2:0][16:0] blend_sum;

  logic rdy3;
  logic rdy4;
  logic rdy5;

  assign rdy5 = !v5_r || out_ready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign in_ready = rdy3;

  // Two-segment ramp: the lower half runs low to mid, the upper half mid
  // to top, each with t = 2n over its own half.
  always_comb begin
    n_low = in_data.n < HALF_Q8;
    n_off = in_data.n - HALF_Q8;
    t = n_low ? {1'b0, in_data.n[6:0], 1'b0} : {n_off[7:0], 1'b0};
    t_inv = ONE_Q8 - t;
    for (int c = 0; c < 3; c++) begin
      ramp_sum[c] = 17'(t_inv) * 17'(n_low ? GRASS_LOW_RGB[c] : GRASS_MID_RGB[c])
                  + 17'(t) * 17'(n_low ? GRASS_MID_RGB[c] : GRASS_TOP_RGB[c]);
      g3_nxt[c] = ramp_sum[c][15:8];
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mix_sum[c] = 17'(SED_MIX_Q8) * 17'(SED_RGB[c]) + 17'(GRASS_MIX_Q8) * 17'(g3_r[c]);
    end
    if (bare3_r) begin
      land4_nxt = ROCK_RGB;
    end else if (chan3_r) begin
      land4_nxt = SED_RGB;
    end else begin
      for (int c = 0; c < 3; c++) begin
        land4_nxt[c] = mix_sum[c][15:8];
      end
    end
  end

  always_comb begin
    alpha_inv = ONE_Q8 - alpha4_r;
    for (int c = 0; c < 3; c++) begin
      blend_sum[c] = 17'(alpha_inv) * 17'(land4_r[c]) + 17'(alpha4_r) * 17'(WATER_RGB[c]);
      rgb5_nxt[c] = blend_sum[c][15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy3) begin
        v3_r <= in_valid;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
      if (rdy5) begin
        v5_r <= v4_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy3) begin
      bare3_r <= in_data.bare;
      chan3_r <= in_data.chan;
      alpha3_r <= in_data.alpha;
      g3_r <= g3_nxt;
    end
    if (v3_r && rdy4) begin
      alpha4_r <= alpha3_r;
      land4_r <= land4_nxt;
    end
    if (v4_r && rdy5) begin
      rgb5_r <= rgb5_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_item.red = rgb5_r[2];
  assign out_item.green = rgb5_r[1];
  assign out_item.blue = rgb5_r[0];

endmodule

`default_nettype wire

[hw/rtl/terrain_cell_colorizer_top.sv]
// ----------------------------------------------------------------------------
// terrain_cell_colorizer_top
// Top-view RGB color of one terrain cell from soil, height, water and flow.
// ----------------------------------------------------------------------------
// The block takes one terrain cell per clock while the output side is ready
// and returns one RGB color per cell, in order. It is a five-stage pipeline:
// classification, reciprocal scaling, grass ramp, land mix and water blend,
// each ending in a register with its own valid bit. A stall on the output
// holds the last stage and lets the stages behind it fill, so bubbles are
// squeezed out before the input is held. Configuration registers are
// written through cfg_wr_en, cfg_index and cfg_data and must only change
// while no cell is in flight; writes to an unused index are ignored.
`default_nettype none

module terrain_cell_colorizer_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire tcc_pkg::in_item_t               in_item,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output tcc_pkg::out_item_t                   out_item,
  input  wire logic                            cfg_wr_en,
  input  wire logic [tcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [15:0]                     cfg_data
);
  import tcc_pkg::*;

  cfg_t cfg_r;
  logic s1_valid;
  logic s1_ready;
  s1_t  s1_data;
  logic s2_valid;
  logic s2_ready;
  s2_t  s2_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bare_soil_limit_mm <= RST_BARE_SOIL_LIMIT;
      cfg_r.channel_flow_limit <= RST_CHANNEL_FLOW_LIMIT;
      cfg_r.height_base_mm <= RST_HEIGHT_BASE;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_BARE_SOIL_LIMIT: begin
          cfg_r.bare_soil_limit_mm <= cfg_data;
        end
        CFG_CHANNEL_FLOW_LIMIT: begin
          cfg_r.channel_flow_limit <= cfg_data;
        end
        CFG_HEIGHT_BASE: begin
          cfg_r.height_base_mm <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  tcc_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  tcc_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  tcc_color u_color (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
